@@ src/lap3d_pkg.sv @@
// Shared constants and types of the 3-D seven-point Laplacian stencil.
package lap3d_pkg;

  // Configuration port and register layout.
  localparam int CFG_INDEX_BITS = 4;
  localparam int CFG_DATA_BITS = 16;
  localparam int GRID_SIDE_BITS = 6;
  localparam int PLANES_BITS = 16;

  localparam logic [CFG_INDEX_BITS-1:0] REG_GRID_SIDE = CFG_INDEX_BITS'(0);
  localparam logic [CFG_INDEX_BITS-1:0] REG_INTERIOR_PLANES = CFG_INDEX_BITS'(1);

  localparam int GRID_SIDE_RESET = 32;
  localparam int INTERIOR_PLANES_RESET = 32;

  // Plane index within one grid, halo planes included.
  localparam int PLANE_BITS = PLANES_BITS + 1;

  // Extra result bits over a sample: twelve weights in total.
  localparam int GROWTH_BITS = 4;

  // Plane buffer rotation codes.
  localparam logic [1:0] BUF_0 = 2'd0;
  localparam logic [1:0] BUF_1 = 2'd1;
  localparam logic [1:0] BUF_2 = 2'd2;

  // Read ports of the replicated plane memory.
  localparam int RD_LOW = 0;
  localparam int RD_MID = 1;
  localparam int RD_RP = 2;
  localparam int RD_RN = 3;
  localparam int RD_CP = 4;
  localparam int RD_CN = 5;
  localparam int RD_PORTS = 6;
  localparam int MEM_COPIES = 3;

  // Control that travels with each result through the pipeline.
  typedef struct packed {
    logic valid;
    logic last;
  } lap3d_ctl_t;

endpackage

@@ src/laplace_stencil_3d_periodic.sv @@
// Top level of the streaming 3-D seven-point Laplacian with periodic rows and columns.
//
// Usage: samples enter on the in_* request channel in raster order (plane, row,
// column): one halo plane below, the configured number of interior planes, then
// one halo plane above, each plane grid_side rows of grid_side samples. While a
// plane arrives, each sample yields one result on the out_* channel: the
// Laplacian of the previous plane at the same row and column. The lower halo
// and first interior planes give no result; is_last_o marks the final result of a grid.
// Configuration requests on cfg_* are always taken and restart the grid; they
// are meant to be issued only while the block is idle.
// A sample passes through the memory read register, two adder stages and the
// output register. Throughput: one sample per cycle while the receiver keeps up,
// set by the plane memory, which is held in three copies with one write and two
// read ports each to serve six reads a cycle.
// Reset clears the counters and the pipeline valid bits and loads the register
// defaults; the plane memory needs no clearing pass, since every entry read was
// written earlier in the same grid. When the receiver stalls, results stay in
// the pipeline registers, bubbles close up, and input is refused only once
// every stage holds a result.
module laplace_stencil_3d_periodic #(
  parameter int MAX_SIDE = 32,
  parameter int SAMPLE_BITS = 24
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // Configuration requests.
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [lap3d_pkg::CFG_INDEX_BITS-1:0] cfg_index_i,
  input  logic [lap3d_pkg::CFG_DATA_BITS-1:0]  cfg_data_i,
  // Sample stream.
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic signed [SAMPLE_BITS-1:0]        sample_i,
  // Result stream.
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [SAMPLE_BITS+lap3d_pkg::GROWTH_BITS-1:0] laplacian_o,
  output logic                                 is_last_o
);
  import lap3d_pkg::*;

  localparam int RW = $clog2(MAX_SIDE);
  localparam int AW = 2 + 2 * RW;
  localparam int DEPTH = 3 << (2 * RW);
  localparam int RB = SAMPLE_BITS + GROWTH_BITS;
  localparam int RST_SIDE = (GRID_SIDE_RESET > MAX_SIDE) ? MAX_SIDE : GRID_SIDE_RESET;

  // ---------------------------------------------------------------------------
  // Configuration registers, held in the form the datapath uses them: the
  // clamped side minus one, and the index of the upper halo plane.
  // ---------------------------------------------------------------------------
  logic [RW-1:0]         side_m1_q, side_m1_d;
  logic [PLANE_BITS-1:0] last_q, last_d;
  logic [GRID_SIDE_BITS-1:0] cfg_side;
  logic [PLANES_BITS-1:0]    cfg_planes;
  logic                  cfg_fire;

  assign cfg_ready_o = 1'b1;
  assign cfg_fire = cfg_valid_i & cfg_ready_o;
  assign cfg_side = cfg_data_i[GRID_SIDE_BITS-1:0];
  assign cfg_planes = cfg_data_i[PLANES_BITS-1:0];

  always_comb begin
    side_m1_d = side_m1_q;
    last_d = last_q;
    if (cfg_index_i == REG_GRID_SIDE) begin
      // A side of zero behaves as one; anything above the buffer size is capped.
      if (cfg_side == '0) begin
        side_m1_d = '0;
      end else if (int'(cfg_side) > MAX_SIDE) begin
        side_m1_d = RW'(MAX_SIDE - 1);
      end else begin
        side_m1_d = RW'(cfg_side - 1'b1);
      end
    end
    if (cfg_index_i == REG_INTERIOR_PLANES) begin
      // Zero interior planes behave as one.
      if (cfg_planes == '0) begin
        last_d = PLANE_BITS'(2);
      end else begin
        last_d = PLANE_BITS'(cfg_planes) + PLANE_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_m1_q <= RW'(RST_SIDE - 1);
      last_q <= PLANE_BITS'(INTERIOR_PLANES_RESET + 1);
    end else if (cfg_fire) begin
      side_m1_q <= side_m1_d;
      last_q <= last_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline handshake. Each stage loads when it is empty or its successor
  // moves on, so bubbles close up under a stalled receiver.
  // ---------------------------------------------------------------------------
  lap3d_ctl_t ctl_a_q, ctl_b_q, ctl_c_q, ctl_d_q;
  logic rdy_a, rdy_b, rdy_c, rdy_d;
  logic in_fire;

  assign rdy_d = ~ctl_d_q.valid | out_ready_i;
  assign rdy_c = ~ctl_c_q.valid | rdy_d;
  assign rdy_b = ~ctl_b_q.valid | rdy_c;
  assign rdy_a = ~ctl_a_q.valid | rdy_b;
  assign in_ready_o = rdy_a;
  assign in_fire = in_valid_i & rdy_a;

  // ---------------------------------------------------------------------------
  // Raster position and plane buffer rotation.
  // ---------------------------------------------------------------------------
  logic [PLANE_BITS-1:0] plane_q;
  logic [RW-1:0]         row_q, col_q;
  logic [1:0]            rot_q;
  logic [1:0]            mid_buf, low_buf;
  logic                  end_row, end_plane, emit, grid_end;
  logic [RW-1:0]         row_p, row_n, col_p, col_n;

  assign end_row = (col_q == side_m1_q);
  assign end_plane = end_row & (row_q == side_m1_q);
  // The lower halo and the first real plane only fill the buffers.
  assign emit = (plane_q > PLANE_BITS'(1));
  assign grid_end = end_plane & (plane_q >= last_q);

  // The arriving plane goes to rot_q; the plane one below sits in the buffer
  // before it and the plane two below in the buffer after it.
  always_comb begin
    case (rot_q)
      BUF_0: begin
        mid_buf = BUF_2;
        low_buf = BUF_1;
      end
      BUF_1: begin
        mid_buf = BUF_0;
        low_buf = BUF_2;
      end
      BUF_2: begin
        mid_buf = BUF_1;
        low_buf = BUF_0;
      end
      default: begin
        mid_buf = BUF_2;
        low_buf = BUF_1;
      end
    endcase
  end

  // Periodic neighbours in the plane.
  assign row_p = (row_q == '0) ? side_m1_q : row_q - 1'b1;
  assign row_n = (row_q == side_m1_q) ? '0 : row_q + 1'b1;
  assign col_p = (col_q == '0) ? side_m1_q : col_q - 1'b1;
  assign col_n = (col_q == side_m1_q) ? '0 : col_q + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plane_q <= '0;
      row_q <= '0;
      col_q <= '0;
      rot_q <= BUF_0;
    end else if (cfg_fire) begin
      // Any configuration request restarts the grid; buffer contents stay.
      plane_q <= '0;
      row_q <= '0;
      col_q <= '0;
      rot_q <= BUF_0;
    end else if (in_fire) begin
      if (!end_row) begin
        col_q <= col_q + 1'b1;
      end else if (!end_plane) begin
        col_q <= '0;
        row_q <= row_q + 1'b1;
      end else if (grid_end) begin
        plane_q <= '0;
        row_q <= '0;
        col_q <= '0;
        rot_q <= BUF_0;
      end else begin
        col_q <= '0;
        row_q <= '0;
        plane_q <= plane_q + 1'b1;
        rot_q <= (rot_q == BUF_2) ? BUF_0 : rot_q + 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage A: plane memory. Every copy takes the same write; each serves two of
  // the six reads. Reads and the write of one sample share a clock edge, so a
  // sample written at the previous edge is already visible, which covers a side
  // of one, where every in-plane read hits the sample taken just before.
  // ---------------------------------------------------------------------------
  logic signed [SAMPLE_BITS-1:0] plane_mem [MEM_COPIES][DEPTH];
  logic [AW-1:0]                 wr_addr;
  logic [AW-1:0]                 rd_addr [RD_PORTS];
  logic signed [SAMPLE_BITS-1:0] rd_q [RD_PORTS];
  logic signed [SAMPLE_BITS-1:0] x_q;

  assign wr_addr = {rot_q, row_q, col_q};
  assign rd_addr[RD_LOW] = {low_buf, row_q, col_q};
  assign rd_addr[RD_MID] = {mid_buf, row_q, col_q};
  assign rd_addr[RD_RP] = {mid_buf, row_p, col_q};
  assign rd_addr[RD_RN] = {mid_buf, row_n, col_q};
  assign rd_addr[RD_CP] = {mid_buf, row_q, col_p};
  assign rd_addr[RD_CN] = {mid_buf, row_q, col_n};

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      for (int k = 0; k < MEM_COPIES; k++) begin
        plane_mem[k][wr_addr] <= sample_i;
      end
      if (emit) begin
        rd_q[RD_LOW] <= plane_mem[0][rd_addr[RD_LOW]];
        rd_q[RD_MID] <= plane_mem[0][rd_addr[RD_MID]];
        rd_q[RD_RP] <= plane_mem[1][rd_addr[RD_RP]];
        rd_q[RD_RN] <= plane_mem[1][rd_addr[RD_RN]];
        rd_q[RD_CP] <= plane_mem[2][rd_addr[RD_CP]];
        rd_q[RD_CN] <= plane_mem[2][rd_addr[RD_CN]];
        x_q <= sample_i;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage B: pairwise sums and six times the centre, all at full result width.
  // ---------------------------------------------------------------------------
  logic signed [RB-1:0] ext [RD_PORTS];
  logic signed [RB-1:0] ext_x;
  logic signed [RB-1:0] sum_xl_q, sum_rows_q, sum_cols_q, ctr6_q;

  always_comb begin
    for (int i = 0; i < RD_PORTS; i++) begin
      ext[i] = {{GROWTH_BITS{rd_q[i][SAMPLE_BITS-1]}}, rd_q[i]};
    end
    ext_x = {{GROWTH_BITS{x_q[SAMPLE_BITS-1]}}, x_q};
  end

  always_ff @(posedge clk_i) begin
    if (ctl_a_q.valid && rdy_b) begin
      sum_xl_q <= ext_x + ext[RD_LOW];
      sum_rows_q <= ext[RD_RP] + ext[RD_RN];
      sum_cols_q <= ext[RD_CP] + ext[RD_CN];
      ctr6_q <= (ext[RD_MID] <<< 2) + (ext[RD_MID] <<< 1);
    end
  end

  // ---------------------------------------------------------------------------
  // Stage C: two partial sums.
  // ---------------------------------------------------------------------------
  logic signed [RB-1:0] part_a_q, part_b_q;

  always_ff @(posedge clk_i) begin
    if (ctl_b_q.valid && rdy_c) begin
      part_a_q <= sum_xl_q + sum_rows_q;
      part_b_q <= sum_cols_q - ctr6_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage D: output register. The sum is exact in the result width.
  // ---------------------------------------------------------------------------
  logic signed [RB-1:0] lap_q;

  always_ff @(posedge clk_i) begin
    if (ctl_c_q.valid && rdy_d) begin
      lap_q <= part_a_q + part_b_q;
    end
  end

  // Valid and last flags move with their data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_a_q <= '0;
      ctl_b_q <= '0;
      ctl_c_q <= '0;
      ctl_d_q <= '0;
    end else begin
      if (rdy_a) begin
        ctl_a_q.valid <= in_fire & emit;
        ctl_a_q.last <= grid_end;
      end
      if (rdy_b) begin
        ctl_b_q <= ctl_a_q;
      end
      if (rdy_c) begin
        ctl_c_q <= ctl_b_q;
      end
      if (rdy_d) begin
        ctl_d_q <= ctl_c_q;
      end
    end
  end

  assign out_valid_o = ctl_d_q.valid;
  assign is_last_o = ctl_d_q.last;
  assign laplacian_o = lap_q;

endmodule

@@ bench/laplace_stencil_3d_periodic_tb.sv @@
// Self-checking testbench of the streaming 3-D seven-point Laplacian with periodic rows and columns.
`timescale 1ns / 100ps

module laplace_stencil_3d_periodic_tb;
  import lap3d_pkg::*;

  localparam int MAX_SIDE = 32;
  localparam int SAMPLE_W = 24;
  localparam int RESULT_W = SAMPLE_W + GROWTH_BITS;
  localparam int CLK_PERIOD = 10;
  localparam int RESET_CYCLES = 6;
  // Covers the pipeline latency with a generous margin.
  localparam int SETTLE_CYCLES = 10;
  // The longest legal quiet spell is a sender gap, a receiver stall and a
  // pause between phases; this is far beyond any of them.
  localparam int QUIET_LIMIT = 1000;
  localparam int RANDOM_SAMPLES = 400;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [RESULT_W-1:0] lap_t;

  typedef struct {
    lap_t laplacian;
    logic is_last;
  } result_t;

  localparam sample_t SAMPLE_MAX = sample_t'(2 ** (SAMPLE_W - 1) - 1);
  localparam sample_t SAMPLE_MIN = sample_t'(-(2 ** (SAMPLE_W - 1)));

  logic                      clk_i = 1'b0;
  logic                      rst_ni;
  logic                      cfg_valid_i;
  logic                      cfg_ready_o;
  logic [CFG_INDEX_BITS-1:0] cfg_index_i;
  logic [CFG_DATA_BITS-1:0]  cfg_data_i;
  logic                      in_valid_i;
  logic                      in_ready_o;
  sample_t                   sample_i;
  logic                      out_valid_o;
  logic                      out_ready_i;
  lap_t                      laplacian_o;
  logic                      is_last_o;

  laplace_stencil_3d_periodic #(
    .MAX_SIDE   (MAX_SIDE),
    .SAMPLE_BITS(SAMPLE_W)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sample_i   (sample_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .laplacian_o(laplacian_o),
    .is_last_o  (is_last_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Samples waiting to be offered, and the Laplacians that the block owes us.
  sample_t samples_to_send[$];
  result_t laplacians_due[$];

  // Handshake outcomes of the latest rising edge, read by the falling-edge drivers.
  bit sample_taken;
  bit result_taken;

  // When set, the matching side runs back to back for the current phase.
  bit send_steady;
  bit recv_steady;

  int mismatches;

  // Our own copy of the block's registers and of its grid walk. The plane
  // buffers are indexed by rotation slot, row and column.
  logic [GRID_SIDE_BITS-1:0] side_reg = GRID_SIDE_BITS'(GRID_SIDE_RESET);
  logic [PLANES_BITS-1:0]    planes_reg = PLANES_BITS'(INTERIOR_PLANES_RESET);
  sample_t                   plane_buf[3][MAX_SIDE][MAX_SIDE];
  int                        plane_at;
  int                        row_at;
  int                        col_at;
  logic [1:0]                slot_at;

  task automatic report_mismatch(string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatches++;
  endtask

  function automatic int draw_gap(bit steady);
    return steady ? 0 : $urandom_range(0, 11);
  endfunction

  // A register write, whatever its index, sends the block back to the first
  // halo plane; the buffers keep what they hold.
  function automatic void restart_grid();
    plane_at = 0;
    row_at = 0;
    col_at = 0;
    slot_at = BUF_0;
  endfunction

  // Takes one accepted sample through our copy of the grid walk and queues
  // the Laplacian that it should produce, if any.
  function automatic void stencil_predict(sample_t x);
    int side, last_plane, r, c, cur, mid, low, rp, rn, cp, cn;
    bit end_row, end_plane;
    result_t res;
    // Out-of-range registers are clamped: a side of zero acts as one, a side
    // beyond the buffers as the largest, and zero interior planes as one.
    side = (side_reg == 0) ? 1 : ((side_reg > MAX_SIDE) ? MAX_SIDE : int'(side_reg));
    last_plane = ((planes_reg == 0) ? 1 : int'(planes_reg)) + 1;
    r = (row_at >= side) ? side - 1 : row_at;
    c = (col_at >= side) ? side - 1 : col_at;
    cur = int'(slot_at);
    mid = (cur + 2) % 3;
    low = (cur + 1) % 3;
    plane_buf[cur][r][c] = x;
    end_row = (c + 1 >= side);
    end_plane = end_row && (r + 1 >= side);
    // The lower halo and the first interior plane only fill the buffers.
    if (plane_at >= 2) begin
      rp = (r == 0) ? side - 1 : r - 1;
      rn = (r + 1 >= side) ? 0 : r + 1;
      cp = (c == 0) ? side - 1 : c - 1;
      cn = (c + 1 >= side) ? 0 : c + 1;
      // With a side of one, all four in-plane neighbours are the centre.
      res.laplacian = x + plane_buf[low][r][c]
                      + plane_buf[mid][rp][c] + plane_buf[mid][rn][c]
                      + plane_buf[mid][r][cp] + plane_buf[mid][r][cn]
                      - 6 * plane_buf[mid][r][c];
      res.is_last = end_plane && (plane_at >= last_plane);
      laplacians_due.push_back(res);
    end
    if (!end_row) begin
      col_at = c + 1;
      row_at = r;
    end else if (!end_plane) begin
      col_at = 0;
      row_at = r + 1;
    end else if (plane_at >= last_plane) begin
      restart_grid();
    end else begin
      col_at = 0;
      row_at = 0;
      plane_at++;
      slot_at = 2'((cur + 1) % 3);
    end
  endfunction

  // Mostly full-range values, with the extremes and the values around zero
  // drawn often enough to land on every neighbour position.
  function automatic sample_t random_sample();
    case ($urandom_range(0, 15))
      0: return SAMPLE_MAX;
      1: return SAMPLE_MIN;
      2: return '0;
      3: return '1;
      default: return sample_t'($urandom());
    endcase
  endfunction

  // Queues a whole grid of random samples, or only its first cut samples
  // when cut falls inside it, and returns how many were queued.
  function automatic int queue_grid(int side, int planes, int cut);
    int total;
    total = side * side * (planes + 2);
    if (cut > 0 && cut < total) total = cut;
    for (int i = 0; i < total; i++) samples_to_send.push_back(random_sample());
    return total;
  endfunction

  // Configuration requests are issued only while the block is idle, so our
  // copy is updated at the edge that takes the request.
  task automatic write_register(logic [CFG_INDEX_BITS-1:0] index,
                                logic [CFG_DATA_BITS-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (index == REG_GRID_SIDE) side_reg = data[GRID_SIDE_BITS-1:0];
    else if (index == REG_INTERIOR_PLANES) planes_reg = data;
    restart_grid();
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Waits until every queued sample has been taken and every owed Laplacian
  // has arrived, then lets the pipeline settle. Samples of the lower halo and
  // the first interior plane give nothing back, so the settling time also
  // covers a phase that stops part-way into a grid.
  task automatic drain();
    do @(posedge clk_i);
    while (samples_to_send.size() != 0 || in_valid_i || laplacians_due.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Sample sender. A request stays up with its sample until taken; after each
  // taken request a fresh gap is drawn before the next one is offered.
  always @(negedge clk_i) begin : drive_samples
    int send_gap;
    logic hold;
    if (rst_ni) begin
      hold = in_valid_i && !sample_taken;
      if (sample_taken) send_gap = draw_gap(send_steady);
      if (!hold && send_gap == 0 && samples_to_send.size() > 0) begin
        sample_i <= samples_to_send.pop_front();
        hold = 1'b1;
      end else if (!hold && send_gap > 0) begin
        send_gap--;
      end
      in_valid_i <= hold;
    end
  end

  // Result receiver: after each result taken, ready drops for a drawn number
  // of cycles, so that back-pressure reaches the sample side as well.
  always @(negedge clk_i) begin : drive_ready
    int stall_left;
    if (rst_ni) begin
      if (result_taken) stall_left = draw_gap(recv_steady);
      else if (stall_left > 0) stall_left--;
      out_ready_i <= (stall_left == 0);
    end
  end

  // Everything is observed at the rising edge. The result is checked before
  // the sample of the same edge is predicted, since no result can come from
  // a sample taken at that very edge.
  always @(posedge clk_i) begin : observe
    int quiet_cycles;
    result_t due;
    sample_taken = in_valid_i && in_ready_o;
    result_taken = out_valid_o && out_ready_i;
    if (result_taken) begin
      if (laplacians_due.size() == 0) begin
        report_mismatch($sformatf("result %0d with no Laplacian owed", laplacian_o));
      end else begin
        due = laplacians_due.pop_front();
        if (laplacian_o !== due.laplacian)
          report_mismatch($sformatf("laplacian %0d, predicted %0d",
                                    laplacian_o, due.laplacian));
        if (is_last_o !== due.is_last)
          report_mismatch($sformatf("is_last %b, predicted %b", is_last_o, due.is_last));
      end
    end
    if (sample_taken) stencil_predict(sample_i);
    // Watchdog: any accepted request on any channel proves progress.
    if (rst_ni) begin
      if (sample_taken || result_taken || (cfg_valid_i && cfg_ready_o)) begin
        quiet_cycles = 0;
      end else if (++quiet_cycles >= QUIET_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int side, planes, side_now, planes_now, picks, sent;
    bit planes_first;
    logic [CFG_DATA_BITS-1:0] side_word, planes_word;

    rst_ni = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    sample_i = '0;
    out_ready_i = 1'b0;
    restart_grid();
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Side of one with zero interior planes, which acts as one: every
    // in-plane neighbour is the centre, and each grid is a single result
    // marked last. The upper bits of the side word must be ignored. The two
    // grids put the sample extremes against each other in both directions.
    write_register(REG_GRID_SIDE, 16'hFFC1);
    write_register(REG_INTERIOR_PLANES, 16'h0000);
    samples_to_send = {SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MIN,
                       SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MAX};
    drain();

    // Side of two: both row neighbours and both column neighbours of a
    // position are the same sample, seen through the periodic wrap.
    write_register(REG_GRID_SIDE, 16'h0002);
    write_register(REG_INTERIOR_PLANES, 16'h0001);
    samples_to_send = {SAMPLE_MAX, SAMPLE_MIN, sample_t'(0), sample_t'(-1),
                       sample_t'(1), SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MAX,
                       SAMPLE_MIN, sample_t'(-1), SAMPLE_MAX, sample_t'(0)};
    drain();

    // The largest plane count, with a zero side that acts as one; the grid is
    // left unfinished and the next register write starts afresh.
    send_steady = ($urandom_range(0, 1) == 1);
    write_register(REG_GRID_SIDE, 16'hFFC0);
    write_register(REG_INTERIOR_PLANES, 16'hFFFF);
    sent = queue_grid(1, 2, 40);
    drain();

    // The largest side, reached through a side word beyond the buffers that
    // is clamped, streamed back to back to keep the run short. The grid stops
    // after the first row of results and one sample more, which already
    // covers the row and column wrap at the largest side.
    send_steady = 1'b1;
    recv_steady = 1'b1;
    write_register(REG_INTERIOR_PLANES, 16'h0001);
    write_register(REG_GRID_SIDE, 16'hFFFF);
    sent = queue_grid(MAX_SIDE, 1, 2 * MAX_SIDE * MAX_SIDE + MAX_SIDE + 1);
    drain();

    // Random phases: small grids with random content, a few cut short as
    // broken sequences, each phase under a new register setting.
    side_now = MAX_SIDE;
    planes_now = 1;
    sent = 0;
    while (sent < RANDOM_SAMPLES) begin
      send_steady = ($urandom_range(0, 3) == 0);
      recv_steady = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 9))
        7: side = 1;
        8: side = $urandom_range(6, 8);
        9: side = 2;
        default: side = $urandom_range(1, 5);
      endcase
      planes = $urandom_range(1, 5);
      side_word = {10'($urandom()), 6'(side)};
      if (side == 1 && $urandom_range(0, 1) == 1) side_word[GRID_SIDE_BITS-1:0] = '0;
      planes_word = 16'(planes);
      if (planes == 1 && $urandom_range(0, 1) == 1) planes_word = '0;

      // Sometimes only one register changes; that is safe only while the
      // other one still holds a small value.
      picks = (side_now <= 8) ? $urandom_range(0, 5) : 2;
      if (picks == 0) planes = planes_now;
      else if (picks == 1) side = side_now;
      planes_first = ($urandom_range(0, 1) == 1);
      if (planes_first && picks != 0) write_register(REG_INTERIOR_PLANES, planes_word);
      if (picks != 1) write_register(REG_GRID_SIDE, side_word);
      if (!planes_first && picks != 0) write_register(REG_INTERIOR_PLANES, planes_word);
      // A write past the register list changes nothing but still restarts.
      if ($urandom_range(0, 5) == 0)
        write_register(CFG_INDEX_BITS'($urandom_range(REG_INTERIOR_PLANES + 1,
                                                      2 ** CFG_INDEX_BITS - 1)),
                       16'($urandom()));
      side_now = side;
      planes_now = planes;

      repeat ($urandom_range(1, 2)) sent += queue_grid(side, planes, 0);
      if ($urandom_range(0, 3) == 0)
        sent += queue_grid(side, planes,
                           $urandom_range(1, side * side * (planes + 2) - 1));
      drain();
    end

    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
